FILE: hdl/multi_slot_alarm_matcher_top_macros.svh
// Assertion macros shared by the alarm matcher RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MULTI_SLOT_ALARM_MATCHER_TOP_MACROS_SVH
`define MULTI_SLOT_ALARM_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSAM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alarm matcher assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSAM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alarm matcher assertion failed");

`endif

FILE: hdl/msam_pkg.sv
// Package for the alarm matcher: field widths, constants and word types.
// Depends on nothing; used by every module of the block.
package msam_pkg;

    // Number of alarm slots and configuration registers.
    localparam int SLOTS      = 4;
    localparam int CFG_REGS   = 4;
    localparam int CFG_IDX_W  = $clog2(CFG_REGS);

    // Field widths.
    localparam int WORD_W     = 12;
    localparam int STAMP_W    = 27;
    localparam int HOUR24_W   = 5;
    localparam int HOUR12_W   = 4;
    localparam int MIN_W      = 6;
    localparam int DELTA_W    = 11;
    localparam int SLOT_W     = 2;
    localparam int EPOCH_W    = 32;

    // Opcodes of an input word.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    // Constants of the time arithmetic.
    localparam logic [WORD_W-1:0]   WORD_RESET  = 12'h700;
    localparam logic [EPOCH_W-1:0]  SYNC_EPOCH  = 32'd1700000000;
    localparam logic [DELTA_W-1:0]  DAY_MINUTES = 11'd1440;
    localparam logic [DELTA_W-1:0]  HOUR_MINUTES = 11'd60;
    // Reciprocal of 15 for (epoch >> 2) / 15, exact over 32-bit inputs with a shift of 35.
    localparam logic [31:0]         DIV15_MAGIC = 32'h8888_8889;
    localparam int                  DIV15_SHIFT = 35;
    localparam int                  PROD_W      = 62;

    typedef struct packed {
        logic                opcode;
        logic [EPOCH_W-1:0]  epoch_seconds;
        logic [HOUR24_W-1:0] local_hour;
        logic [MIN_W-1:0]    local_minute;
    } in_word_t;

    typedef struct packed {
        logic                fire;
        logic [SLOT_W-1:0]   fire_slot;
        logic                pending_held;
        logic                next_found;
        logic [HOUR12_W-1:0] next_hour;
        logic [MIN_W-1:0]    next_minute;
        logic                next_is_am;
        logic [DELTA_W-1:0]  next_delta;
    } out_word_t;

    // Broadcast from the scan stage to every cell.
    typedef struct packed {
        logic                scan_en;
        logic [STAMP_W-1:0]  stamp;
        logic [HOUR24_W-1:0] local_hour;
        logic [MIN_W-1:0]    local_minute;
        logic [DELTA_W-1:0]  now_min;
    } scan_t;

    // Passed from each cell to its right neighbor.
    typedef struct packed {
        logic                fire;
        logic [SLOT_W-1:0]   fire_slot;
        logic                found;
        logic [DELTA_W-1:0]  delta;
        logic [HOUR12_W-1:0] hour;
        logic [MIN_W-1:0]    minute;
        logic                am;
    } chain_t;

endpackage

FILE: hdl/msam_cell.sv
// One alarm slot cell: holds the slot word and its last fire stamp.
// Depends on msam_pkg; instantiated in a row by multi_slot_alarm_matcher_top.
module msam_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [msam_pkg::WORD_W-1:0]   wr_data,
    input  logic [msam_pkg::SLOT_W-1:0]   slot_id,
    input  msam_pkg::scan_t               scan,
    input  msam_pkg::chain_t              chain_in,
    output msam_pkg::chain_t              chain_out
);
    import msam_pkg::*;

    logic [WORD_W-1:0]   word_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic                en;
    logic                am;
    logic [HOUR12_W-1:0] raw_hour;
    logic [HOUR12_W-1:0] hour;
    logic [MIN_W-1:0]    raw_min;
    logic [MIN_W-1:0]    minute;
    logic [HOUR24_W-1:0] hour24;
    logic [DELTA_W-1:0]  amin;
    logic [DELTA_W:0]    delta_wide;
    logic [DELTA_W-1:0]  delta;
    logic                hit;
    logic                take;

    // Unpack the slot word, forcing bad hours to 12 and bad minutes to 0.
    always_comb
    begin
        en       = word_reg[11];
        am       = word_reg[10];
        raw_hour = word_reg[9:6];
        raw_min  = word_reg[5:0];
        hour     = (raw_hour < 4'd1 || raw_hour > 4'd12) ? 4'd12 : raw_hour;
        minute   = (raw_min > 6'd59) ? 6'd0 : raw_min;
        hour24   = ((hour == 4'd12) ? 5'd0 : HOUR24_W'(hour)) + (am ? 5'd0 : 5'd12);
        amin     = DELTA_W'(hour24) * HOUR_MINUTES + DELTA_W'(minute);
    end

    // Minutes from now to this alarm, wrapping to the next day.
    always_comb
    begin
        if (amin > scan.now_min)
        begin
            delta_wide = {1'b0, amin} - {1'b0, scan.now_min};
        end
        else
        begin
            delta_wide = {1'b0, amin} + {1'b0, DAY_MINUTES} - {1'b0, scan.now_min};
        end
        delta = delta_wide[DELTA_W-1:0];
    end

    // Fire match, and the soonest-alarm compare against the left neighbor.
    always_comb
    begin
        hit  = scan.scan_en && !chain_in.fire && en && (stamp_reg != scan.stamp) &&
               (hour24 == scan.local_hour) && (minute == scan.local_minute);
        take = en && (!chain_in.found || (delta < chain_in.delta));
        chain_out.fire      = chain_in.fire || hit;
        chain_out.fire_slot = hit ? slot_id : chain_in.fire_slot;
        chain_out.found     = chain_in.found || en;
        chain_out.delta     = take ? delta  : chain_in.delta;
        chain_out.hour      = take ? hour   : chain_in.hour;
        chain_out.minute    = take ? minute : chain_in.minute;
        chain_out.am        = take ? am     : chain_in.am;
    end

    // Slot word and fire stamp registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= WORD_RESET;
            stamp_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                word_reg <= wr_data;
            end
            if (hit)
            begin
                stamp_reg <= scan.stamp;
            end
        end
    end

endmodule

FILE: hdl/multi_slot_alarm_matcher_top.sv
// Top level of the four-slot alarm matcher: input stage, cell row, output register.
// Depends on msam_pkg, msam_cell and multi_slot_alarm_matcher_top_macros.svh.
//
// Each input word passes two register stages. When the word is accepted, its epoch
// minute (from a 30 by 32 bit reciprocal multiply) and its saturated minute of day are
// loaded into the scan stage. Once the output register is free or drains, the row of
// slot cells runs and loads the output register, which holds the result word until it
// is taken. Both stages take a new word every cycle while results are taken, so the
// block then sustains one word per cycle. The input stalls only while the scan stage
// holds a word and the output register holds a result that is not taken in that cycle.
// Slot words are written through cfg_we, cfg_index and cfg_data and take effect at once.
module multi_slot_alarm_matcher_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_valid,
    output logic                             tick_ready,
    input  msam_pkg::in_word_t               tick_word,
    output logic                             res_valid,
    input  logic                             res_ready,
    output msam_pkg::out_word_t              res_word,
    input  logic                             cfg_we,
    input  logic [msam_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msam_pkg::WORD_W-1:0]      cfg_data
);
    import msam_pkg::*;
    `include "multi_slot_alarm_matcher_top_macros.svh"

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                s1_op_reg;
    logic                s1_synced_reg;
    logic [STAMP_W-1:0]  s1_stamp_reg;
    logic [HOUR24_W-1:0] s1_hour_reg;
    logic [MIN_W-1:0]    s1_min_reg;
    logic [DELTA_W-1:0]  s1_now_reg;
    logic                pending_valid_reg;
    logic                pending_valid_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    out_word_t           res_word_reg;
    logic                accept;
    logic                advance;
    logic [PROD_W-1:0]   prod;
    logic [HOUR24_W-1:0] sat_hour;
    logic [MIN_W-1:0]    sat_min;
    logic [DELTA_W-1:0]  now_min;
    scan_t               scan;
    chain_t              chain [SLOTS+1];

    // Handshake: the scan stage moves when the output register is free or drains.
    assign advance    = s1_valid_reg && (!res_valid_reg || res_ready);
    assign tick_ready = !s1_valid_reg || advance;
    assign accept     = tick_valid && tick_ready;
    assign res_valid  = res_valid_reg;
    assign res_word   = res_word_reg;

    // Input stage: epoch minute by reciprocal multiply, saturated local minute of day.
    always_comb
    begin
        prod     = PROD_W'(tick_word.epoch_seconds[EPOCH_W-1:2]) * PROD_W'(DIV15_MAGIC);
        sat_hour = (tick_word.local_hour > 5'd23) ? 5'd23 : tick_word.local_hour;
        sat_min  = (tick_word.local_minute > 6'd59) ? 6'd59 : tick_word.local_minute;
        now_min  = DELTA_W'(sat_hour) * HOUR_MINUTES + DELTA_W'(sat_min);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= tick_word.opcode;
            s1_synced_reg <= (tick_word.epoch_seconds >= SYNC_EPOCH);
            s1_stamp_reg  <= prod[DIV15_SHIFT+STAMP_W-1:DIV15_SHIFT];
            s1_hour_reg   <= tick_word.local_hour;
            s1_min_reg    <= tick_word.local_minute;
            s1_now_reg    <= now_min;
        end
    end

    // Scan request broadcast to the cells.
    always_comb
    begin
        scan.scan_en      = advance && (s1_op_reg == OP_TICK) && s1_synced_reg &&
                            !pending_valid_reg;
        scan.stamp        = s1_stamp_reg;
        scan.local_hour   = s1_hour_reg;
        scan.local_minute = s1_min_reg;
        scan.now_min      = s1_now_reg;
    end

    // Row of slot cells; the left end starts with nothing found.
    assign chain[0] = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic cell_we;
        assign cell_we = cfg_we && (i < CFG_REGS) && (cfg_index == CFG_IDX_W'(i));

        msam_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (cell_we),
            .wr_data   (cfg_data),
            .slot_id   (SLOT_W'(i)),
            .scan      (scan),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    // Pending fire: set by a fire, cleared by an acknowledge.
    always_comb
    begin
        pending_valid_next = pending_valid_reg;
        if (advance)
        begin
            if (s1_op_reg == OP_ACK)
            begin
                pending_valid_next = 1'b0;
            end
            else if (chain[SLOTS].fire)
            begin
                pending_valid_next = 1'b1;
            end
        end
    end

    // Valid flags of the two stages.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            res_valid_reg     <= 1'b0;
            pending_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            res_valid_reg     <= res_valid_next;
            pending_valid_reg <= pending_valid_next;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_word_reg.fire         <= chain[SLOTS].fire;
            res_word_reg.fire_slot    <= chain[SLOTS].fire_slot;
            res_word_reg.pending_held <= pending_valid_next;
            res_word_reg.next_found   <= chain[SLOTS].found;
            res_word_reg.next_hour    <= chain[SLOTS].hour;
            res_word_reg.next_minute  <= chain[SLOTS].minute;
            res_word_reg.next_is_am   <= chain[SLOTS].am;
            res_word_reg.next_delta   <= chain[SLOTS].delta;
        end
    end

    // A delivered fire always leaves a fire pending.
    `MSAM_ASSERT_IMP(a_fire_pends, clk, rst_n,
                     res_valid_reg && res_word_reg.fire, res_word_reg.pending_held)
    // No slot fires while an earlier fire is still pending.
    `MSAM_ASSERT_IMP(a_no_fire_pending, clk, rst_n, advance && chain[SLOTS].fire, !pending_valid_reg)
    // An acknowledge clears the pending fire.
    `MSAM_ASSERT_NXT(a_ack_clears, clk, rst_n, advance && (s1_op_reg == OP_ACK), !pending_valid_reg)
    // The input side only stalls while both the scan stage and the output register hold a word.
    `MSAM_ASSERT_IMP(a_stall_cause, clk, rst_n, !tick_ready, s1_valid_reg && res_valid_reg)

endmodule

FILE: dv/tb.sv
// Testbench for the four-slot alarm matcher: it drives tick and acknowledge words,
// predicts each result word in a small scoreboard class and compares it field by field.
// Depends on msam_pkg and the multi_slot_alarm_matcher_top RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import msam_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 80;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 200;
    localparam int EN_POS        = 11;
    localparam int AM_POS        = 10;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT0 = '0;

    // One slot word after the hour and minute have been cleaned up.
    typedef struct packed {
        logic                en;
        logic                am;
        logic [HOUR12_W-1:0] hour;
        logic [MIN_W-1:0]    minute;
    } slot_view_t;

    // Scoreboard: keeps its own copy of the slot words and fire state.
    class alarm_scoreboard;
        logic [WORD_W-1:0]  slot_word [SLOTS];
        logic [STAMP_W-1:0] fired_stamp [SLOTS];
        logic               held;
        logic [SLOT_W-1:0]  held_slot;
        out_word_t          due_reports [$];
        int                 mismatches;
        int                 checked;
        int                 fires;
        int                 acks;

        function new();
            foreach (slot_word[i])
            begin
                slot_word[i]   = WORD_RESET;
                fired_stamp[i] = '0;
            end
            held       = 1'b0;
            held_slot  = '0;
            mismatches = 0;
            checked    = 0;
            fires      = 0;
            acks       = 0;
        endfunction

        function void set_slot(int idx, logic [WORD_W-1:0] data);
            slot_word[idx] = data;
        endfunction

        // Out-of-range hours read as 12 and out-of-range minutes as 0.
        function slot_view_t decode(int idx);
            slot_view_t v;
            v.en     = slot_word[idx][EN_POS];
            v.am     = slot_word[idx][AM_POS];
            v.hour   = slot_word[idx][9:6];
            v.minute = slot_word[idx][5:0];
            if (v.hour < 4'd1 || v.hour > 4'd12)
                v.hour = 4'd12;
            if (v.minute > 6'd59)
                v.minute = 6'd0;
            return v;
        endfunction

        function int unsigned hour24(slot_view_t v);
            return (v.hour % 12) + (v.am ? 0 : 12);
        endfunction

        // Work out the result word of one accepted input word.
        function void take_request(in_word_t w);
            out_word_t          r;
            slot_view_t         v;
            logic [STAMP_W-1:0] stamp;
            int unsigned        now_min;
            int unsigned        amin;
            int unsigned        delta;
            r = '0;
            if (w.opcode == OP_ACK)
            begin
                held      = 1'b0;
                held_slot = '0;
                acks++;
            end
            else if (!held && w.epoch_seconds >= SYNC_EPOCH)
            begin
                stamp = STAMP_W'(w.epoch_seconds / 60);
                // The lowest enabled slot that matches and has not fired this minute wins.
                for (int i = 0; i < SLOTS; i++)
                begin
                    v = decode(i);
                    if (v.en && fired_stamp[i] != stamp && !r.fire &&
                        hour24(v) == 32'(w.local_hour) && v.minute == w.local_minute)
                    begin
                        fired_stamp[i] = stamp;
                        held           = 1'b1;
                        held_slot      = SLOT_W'(i);
                        r.fire         = 1'b1;
                        r.fire_slot    = SLOT_W'(i);
                        fires++;
                    end
                end
            end
            // Soonest alarm from the saturated local time, wrapping to the next day.
            now_min = (w.local_hour > 23 ? 23 : w.local_hour) * 60 +
                      (w.local_minute > 59 ? 59 : w.local_minute);
            for (int i = 0; i < SLOTS; i++)
            begin
                v = decode(i);
                if (v.en)
                begin
                    amin  = hour24(v) * 60 + v.minute;
                    delta = (amin > now_min) ? amin - now_min : amin + DAY_MINUTES - now_min;
                    if (!r.next_found || delta < 32'(r.next_delta))
                    begin
                        r.next_found  = 1'b1;
                        r.next_delta  = DELTA_W'(delta);
                        r.next_hour   = v.hour;
                        r.next_minute = v.minute;
                        r.next_is_am  = v.am;
                    end
                end
            end
            r.pending_held = held;
            due_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want_v, got_v);
            end
        endfunction

        // Compare one accepted result word with the oldest prediction.
        function void check_report(out_word_t got);
            out_word_t want;
            if (due_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result word %h with no prediction waiting, expected none",
                         $time, got);
                return;
            end
            want = due_reports.pop_front();
            checked++;
            compare_field("fire", 32'(want.fire), 32'(got.fire));
            compare_field("fire_slot", 32'(want.fire_slot), 32'(got.fire_slot));
            compare_field("pending_held", 32'(want.pending_held), 32'(got.pending_held));
            compare_field("next_found", 32'(want.next_found), 32'(got.next_found));
            compare_field("next_hour", 32'(want.next_hour), 32'(got.next_hour));
            compare_field("next_minute", 32'(want.next_minute), 32'(got.next_minute));
            compare_field("next_is_am", 32'(want.next_is_am), 32'(got.next_is_am));
            compare_field("next_delta", 32'(want.next_delta), 32'(got.next_delta));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  tick_valid;
    logic                  tick_ready;
    in_word_t              tick_word;
    logic                  res_valid;
    logic                  res_ready;
    out_word_t             res_word;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [WORD_W-1:0]     cfg_data;

    alarm_scoreboard       chk;
    int                    snd_idle;
    int                    rcv_idle;
    logic                  stall_request;
    int                    holds_done;
    int                    settings_loaded;
    int                    quiet_cycles;
    logic [EPOCH_W-1:0]    clock_epoch;

    multi_slot_alarm_matcher_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick_word  (tick_word),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_word   (res_word),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Clock.
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Note every accepted word on either channel at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_valid && tick_ready)
                chk.take_request(tick_word);
            if (res_valid && res_ready)
                chk.check_report(res_word);
        end
    end

    // Watchdog: end the run when nothing has been accepted for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (tick_valid && tick_ready) || (res_valid && res_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                stall_request = 1'b0;
                holds_done++;
            end
            res_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    function automatic logic [WORD_W-1:0] pack_slot(logic en, logic am, int hour, int minute);
        return {en, am, HOUR12_W'(hour), MIN_W'(minute)};
    endfunction

    function automatic in_word_t make_item(logic op, logic [EPOCH_W-1:0] ep, int h, int m);
        in_word_t w;
        w.opcode        = op;
        w.epoch_seconds = ep;
        w.local_hour    = HOUR24_W'(h);
        w.local_minute  = MIN_W'(m);
        return w;
    endfunction

    // Mostly ticks at the time of some slot on a running synced clock,
    // with acknowledges, unsynced ticks and raw noise mixed in.
    function automatic in_word_t random_word();
        in_word_t    w;
        slot_view_t  v;
        int unsigned pick;
        pick        = $urandom_range(99);
        clock_epoch = clock_epoch + $urandom_range(90);
        w = make_item(OP_TICK, clock_epoch, $urandom_range(23), $urandom_range(59));
        if (pick < 15)
            w.opcode = OP_ACK;
        else if (pick < 70)
        begin
            v              = chk.decode($urandom_range(SLOTS - 1));
            w.local_hour   = HOUR24_W'(chk.hour24(v));
            w.local_minute = v.minute;
        end
        else if (pick >= 85 && pick < 93)
            w.epoch_seconds = $urandom_range(SYNC_EPOCH - 1, 0);
        else if (pick >= 93)
        begin
            w.opcode        = 1'($urandom_range(1));
            w.epoch_seconds = $urandom;
            w.local_hour    = HOUR24_W'($urandom_range(31));
            w.local_minute  = MIN_W'($urandom_range(63));
        end
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] random_slot_word();
        return {logic'($urandom_range(9) != 0), logic'($urandom_range(1)),
                HOUR12_W'($urandom_range(15)), MIN_W'($urandom_range(63))};
    endfunction

    // Offer one word, after a random gap, and hold it until it is taken.
    task automatic send_word(in_word_t w);
        if ($urandom_range(99) < snd_idle)
        begin
            tick_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < snd_idle);
        end
        tick_valid <= 1'b1;
        tick_word  <= w;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted word has come back.
    task automatic wait_drained();
        tick_valid <= 1'b0;
        while (chk.due_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write all slot words, one per cycle; only called while the block is idle.
    task automatic load_slots(input logic [WORD_W-1:0] words [SLOTS]);
        for (int i = 0; i < SLOTS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(REG_SLOT0 + i);
            cfg_data  <= words[i];
            @(negedge clk);
            chk.set_slot(i, words[i]);
        end
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Main sequence.
    initial
    begin
        logic [WORD_W-1:0] words [SLOTS];
        chk             = new();
        clk             = 1'b0;
        rst_n           = 1'b0;
        tick_valid      = 1'b0;
        tick_word       = '0;
        res_ready       = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        snd_idle        = 0;
        rcv_idle        = 0;
        stall_request   = 1'b0;
        holds_done      = 0;
        settings_loaded = 0;
        quiet_cycles    = 0;
        clock_epoch     = SYNC_EPOCH + $urandom_range(1000000);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // All slots disabled after reset: no soonest alarm.
        send_word(make_item(OP_TICK, '0, 0, 0));
        send_word(make_item(OP_ACK, '1, 31, 63));
        wait_drained();

        // 07:30, 19:30, a bad hour and minute reading as 00:00, and 12:00 PM.
        words = '{pack_slot(1'b1, 1'b1, 7, 30), pack_slot(1'b1, 1'b0, 7, 30),
                  pack_slot(1'b1, 1'b1, 0, 63), pack_slot(1'b1, 1'b0, 15, 60)};
        load_slots(words);
        send_word(make_item(OP_TICK, '0, 7, 30));
        send_word(make_item(OP_TICK, SYNC_EPOCH - 1, 7, 30));
        send_word(make_item(OP_TICK, SYNC_EPOCH, 7, 30));
        // A tick while a fire waits, then acknowledges with and without a pending fire.
        send_word(make_item(OP_TICK, SYNC_EPOCH + 60, 19, 30));
        send_word(make_item(OP_ACK, SYNC_EPOCH + 60, 19, 30));
        send_word(make_item(OP_ACK, SYNC_EPOCH + 61, 19, 30));
        // Same epoch minute as the first fire: slot 0 is skipped.
        send_word(make_item(OP_TICK, SYNC_EPOCH + 39, 7, 30));
        send_word(make_item(OP_TICK, SYNC_EPOCH + 120, 19, 30));
        send_word(make_item(OP_ACK, SYNC_EPOCH + 120, 19, 30));
        send_word(make_item(OP_TICK, SYNC_EPOCH + 180, 0, 0));
        send_word(make_item(OP_ACK, SYNC_EPOCH + 180, 0, 0));
        send_word(make_item(OP_TICK, SYNC_EPOCH + 240, 12, 0));
        send_word(make_item(OP_ACK, SYNC_EPOCH + 240, 12, 0));
        // Ticks at the largest epoch with local time out of range, then one in range.
        send_word(make_item(OP_TICK, '1, 31, 63));
        send_word(make_item(OP_TICK, '1, 24, 0));
        send_word(make_item(OP_TICK, '1, 23, 60));
        send_word(make_item(OP_TICK, '1, 7, 30));
        send_word(make_item(OP_ACK, '0, 23, 59));
        wait_drained();

        // Two slots at the same time: the lower one fires and wins the tie.
        words = '{pack_slot(1'b0, 1'b1, 7, 30), pack_slot(1'b1, 1'b0, 9, 15),
                  pack_slot(1'b1, 1'b1, 9, 15), pack_slot(1'b1, 1'b0, 9, 15)};
        load_slots(words);
        send_word(make_item(OP_TICK, SYNC_EPOCH + 300, 21, 15));
        send_word(make_item(OP_TICK, SYNC_EPOCH + 300, 21, 15));
        send_word(make_item(OP_ACK, SYNC_EPOCH + 300, 21, 15));
        send_word(make_item(OP_TICK, SYNC_EPOCH + 330, 21, 15));
        send_word(make_item(OP_ACK, SYNC_EPOCH + 330, 21, 15));

        // Random part: three idling patterns, two slot settings each.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    snd_idle = 12;
                    rcv_idle = 61;
                end
                1:
                begin
                    snd_idle = 61;
                    rcv_idle = 12;
                end
                default:
                begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
            endcase
            wait_drained();
            for (int i = 0; i < SLOTS; i++)
            begin
                if (seg == 1)
                    words[i] = '1;
                else if (seg == 4)
                    words[i] = '0;
                else
                    words[i] = random_slot_word();
            end
            load_slots(words);
            for (int k = 0; k < SEGMENT_ITEMS; k++)
            begin
                // Long receiver hold-off while words keep coming, to fill the block.
                if (seg == SEGMENTS - 1 && k == SEGMENT_ITEMS / 4)
                    stall_request = 1'b1;
                send_word(random_word());
            end
        end
        wait_drained();

        $display("run covered %0d result words with %0d fires and %0d acknowledges,",
                 chk.checked, chk.fires, chk.acks);
        $display("%0d slot settings and %0d long receiver hold-offs; %0d mismatches",
                 settings_loaded, holds_done, chk.mismatches);
        if (chk.mismatches == 0 && chk.due_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/msam_pkg.sv
hdl/msam_cell.sv
hdl/multi_slot_alarm_matcher_top.sv
dv/tb.sv
